// File: hw/rtl/matrix_multiply_accumulate_defines.svh
// ============================================================================
// Assertion macros for matrix_multiply_accumulate
// Short forms of the clocked properties used by the port checker.
// ============================================================================
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mma_pkg.sv
// ============================================================================
// mma_pkg
// Shared types and constants of the matrix multiply-accumulate block.
// ============================================================================
`timescale 1ns / 1ps

package mma_pkg;

    // Largest matrix dimension by default
    localparam int MAX_DIM_DEF = 8;

    // Field widths
    localparam int DIM_REG_W   = 4;
    localparam int VAL_W       = 16;
    localparam int CELL_W      = 6;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_W     = 24;

    // Arithmetic widths
    localparam int ACC_W       = 35;   // sum of up to eight 32-bit products
    localparam int MUL_B_W     = 27;   // wide multiplier operand (acc >>> 8)
    localparam int PROD_W      = 43;   // 16 x 27 signed product
    localparam int SUM_W       = 36;   // two scaled terms added
    localparam int FRAC_W      = 8;    // Q8.8 fraction bits

    // Reset values of the configuration registers
    localparam logic [DIM_REG_W-1:0] DIM_RST   = 4'd8;
    localparam logic signed [VAL_W-1:0] ALPHA_RST = 16'sd256;
    localparam logic signed [VAL_W-1:0] BETA_RST  = 16'sd0;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] RES_MAX = 36'sd32767;
    localparam logic signed [SUM_W-1:0] RES_MIN = -36'sd32768;

    // Input item kinds
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_LOAD_C = 2'd2,
        ACT_START  = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M_ROWS  = 3'd0,
        REG_N_COLS  = 3'd1,
        REG_K_DEPTH = 3'd2,
        REG_TRANS_A = 3'd3,
        REG_TRANS_B = 3'd4,
        REG_ALPHA   = 3'd5,
        REG_BETA    = 3'd6
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AB_RD,
        ST_AB_MUL,
        ST_AB_ACC,
        ST_C_RD,
        ST_ALPHA_MUL,
        ST_BETA_MUL,
        ST_EMIT
    } seq_state_t;

    // Operand select of the shared multiplier
    typedef enum logic [1:0] {
        MUL_AB,
        MUL_ALPHA,
        MUL_BETA
    } mul_sel_t;

    // Control from the sequencer to the arithmetic unit
    typedef struct packed {
        mul_sel_t sel;
        logic     mul_en;
        logic     acc_clr;
        logic     acc_en;
        logic     sum_en;
    } mac_ctrl_t;

endpackage

// File: hw/rtl/mma_mac.sv
// ============================================================================
// mma_mac
// Shared multiplier with accumulator and scaling adder for one result cell.
// ============================================================================
`timescale 1ns / 1ps

module mma_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mma_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [mma_pkg::VAL_W-1:0]      a_rd,
    input  logic signed [mma_pkg::VAL_W-1:0]      b_rd,
    input  logic signed [mma_pkg::VAL_W-1:0]      c_rd,
    input  logic signed [mma_pkg::VAL_W-1:0]      alpha,
    input  logic signed [mma_pkg::VAL_W-1:0]      beta,
    output logic signed [mma_pkg::VAL_W-1:0]      result
);

    logic signed [mma_pkg::VAL_W-1:0]   op_a;
    logic signed [mma_pkg::MUL_B_W-1:0] op_b;
    logic signed [mma_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mma_pkg::PROD_W-1:0]  prod_next;
    logic signed [mma_pkg::ACC_W-1:0]   acc_reg;
    logic signed [mma_pkg::ACC_W-1:0]   acc_next;
    logic signed [mma_pkg::SUM_W-1:0]   sum_reg;
    logic signed [mma_pkg::SUM_W-1:0]   sum_next;
    logic signed [mma_pkg::SUM_W-1:0]   prod_scaled;
    logic signed [mma_pkg::SUM_W-1:0]   total;

    // Pick the multiplier operands for this step
    always_comb
    begin
        case (ctrl.sel)
            mma_pkg::MUL_AB:
            begin
                op_a = a_rd;
                op_b = mma_pkg::MUL_B_W'(b_rd);
            end
            mma_pkg::MUL_ALPHA:
            begin
                op_a = alpha;
                op_b = mma_pkg::MUL_B_W'(acc_reg >>> mma_pkg::FRAC_W);
            end
            mma_pkg::MUL_BETA:
            begin
                op_a = beta;
                op_b = mma_pkg::MUL_B_W'(c_rd);
            end
            default:
            begin
                op_a = a_rd;
                op_b = mma_pkg::MUL_B_W'(b_rd);
            end
        endcase
    end

    // Floor-shifted product, as it enters the final sum
    assign prod_scaled = mma_pkg::SUM_W'(prod_reg >>> mma_pkg::FRAC_W);

    // Next values of the product, accumulator and partial sum
    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        sum_next  = sum_reg;
        if (ctrl.mul_en)
        begin
            prod_next = mma_pkg::PROD_W'(op_a) * mma_pkg::PROD_W'(op_b);
        end
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + mma_pkg::ACC_W'(prod_reg);
        end
        if (ctrl.sum_en)
        begin
            sum_next = prod_scaled;
        end
    end

    // Hold the datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            sum_reg  <= sum_next;
        end
    end

    // Add both scaled terms and saturate to 16 bits
    assign total = sum_reg + prod_scaled;

    always_comb
    begin
        if (total > mma_pkg::RES_MAX)
        begin
            result = mma_pkg::VAL_W'(mma_pkg::RES_MAX);
        end
        else if (total < mma_pkg::RES_MIN)
        begin
            result = mma_pkg::VAL_W'(mma_pkg::RES_MIN);
        end
        else
        begin
            result = mma_pkg::VAL_W'(total);
        end
    end

endmodule

// File: hw/rtl/mma_seq.sv
// ============================================================================
// mma_seq
// Sequencer that walks cells, inner products and scaling steps of a start.
// ============================================================================
`timescale 1ns / 1ps

module mma_seq #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mma_pkg::DIM_REG_W-1:0]      m_rows,
    input  logic [mma_pkg::DIM_REG_W-1:0]      n_cols,
    input  logic [mma_pkg::DIM_REG_W-1:0]      k_depth,
    input  logic                               trans_a,
    input  logic                               trans_b,
    input  logic                               out_free,
    output logic                               idle,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] c_addr,
    output mma_pkg::mac_ctrl_t                 ctrl,
    output logic                               emit,
    output logic                               emit_last
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    mma_pkg::seq_state_t state_reg;
    mma_pkg::seq_state_t state_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [DIM_W-1:0]    m_dim, n_dim, k_dim;
    logic                dims_ok;
    logic                i_end, j_end, k_end;
    logic                cell_last;

    // Clamp oversized dimensions
    assign m_dim = (m_rows > mma_pkg::DIM_REG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(m_rows);
    assign n_dim = (n_cols > mma_pkg::DIM_REG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(n_cols);
    assign k_dim = (k_depth > mma_pkg::DIM_REG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(k_depth);

    assign dims_ok = (m_rows != '0) && (n_cols != '0) && (k_depth != '0);

    assign i_end     = (i_reg == IDX_W'(m_dim - DIM_W'(1)));
    assign j_end     = (j_reg == IDX_W'(n_dim - DIM_W'(1)));
    assign k_end     = (k_reg == IDX_W'(k_dim - DIM_W'(1)));
    assign cell_last = i_end && j_end;

    // Store offsets of the current operands and cell
    assign a_addr = trans_a ? ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(m_dim) + ADDR_W'(i_reg))
                            : ADDR_W'(ADDR_W'(i_reg) * ADDR_W'(k_dim) + ADDR_W'(k_reg));
    assign b_addr = trans_b ? ADDR_W'(ADDR_W'(j_reg) * ADDR_W'(k_dim) + ADDR_W'(k_reg))
                            : ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(n_dim) + ADDR_W'(j_reg));
    assign c_addr = ADDR_W'(ADDR_W'(i_reg) * ADDR_W'(n_dim) + ADDR_W'(j_reg));

    // Next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (start && dims_ok)
                begin
                    state_next = mma_pkg::ST_AB_RD;
                end
            end
            mma_pkg::ST_AB_RD:
            begin
                state_next = mma_pkg::ST_AB_MUL;
            end
            mma_pkg::ST_AB_MUL:
            begin
                state_next = mma_pkg::ST_AB_ACC;
            end
            mma_pkg::ST_AB_ACC:
            begin
                if (k_end)
                begin
                    state_next = mma_pkg::ST_C_RD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = mma_pkg::ST_AB_RD;
                end
            end
            mma_pkg::ST_C_RD:
            begin
                state_next = mma_pkg::ST_ALPHA_MUL;
            end
            mma_pkg::ST_ALPHA_MUL:
            begin
                state_next = mma_pkg::ST_BETA_MUL;
            end
            mma_pkg::ST_BETA_MUL:
            begin
                state_next = mma_pkg::ST_EMIT;
            end
            mma_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    k_next = '0;
                    if (cell_last)
                    begin
                        state_next = mma_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mma_pkg::ST_AB_RD;
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the arithmetic unit and the result handoff
    always_comb
    begin
        ctrl      = '{sel: mma_pkg::MUL_AB, mul_en: 1'b0, acc_clr: 1'b0,
                      acc_en: 1'b0, sum_en: 1'b0};
        idle      = 1'b0;
        emit      = 1'b0;
        emit_last = cell_last;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                idle         = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            mma_pkg::ST_AB_MUL:
            begin
                ctrl.mul_en = 1'b1;
            end
            mma_pkg::ST_AB_ACC:
            begin
                ctrl.acc_en = 1'b1;
            end
            mma_pkg::ST_ALPHA_MUL:
            begin
                ctrl.sel    = mma_pkg::MUL_ALPHA;
                ctrl.mul_en = 1'b1;
            end
            mma_pkg::ST_BETA_MUL:
            begin
                ctrl.sel    = mma_pkg::MUL_BETA;
                ctrl.mul_en = 1'b1;
                ctrl.sum_en = 1'b1;
            end
            mma_pkg::ST_EMIT:
            begin
                ctrl.acc_clr = 1'b1;
                emit         = out_free;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mma_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

// File: hw/rtl/matrix_multiply_accumulate.sv
// ============================================================================
// matrix_multiply_accumulate
// Matrix multiply-accumulate, C = beta*C + alpha*op(A)*op(B), signed Q8.8.
// Input stream: each item carries an action in s_tuser. Load items write one
// element of A, B or C at the given offset and are taken one per cycle while
// idle; a load whose offset lies beyond the stores is dropped. A start item
// with nonzero dimensions computes every result cell and is the only item that produces output.
// Output stream: one item per cell in row-major order, tlast on the final cell;
// each result is also written back into C.
// Sequence: one shared multiplier does all products. A cell steps through a read,
// a multiply and an accumulate state per inner-product term, then C read, alpha
// and beta scaling and the handoff. s_tready is low while a start runs.
// Stall: a result waits in the output register; if the receiver stalls, the
// sequencer holds at the next cell's handoff until the register frees.
// Reset: configuration returns to 8x8x8, no transposition, alpha 1.0, beta 0;
// the stores hold nothing defined until loaded and need no clearing pass.
// ============================================================================
`timescale 1ns / 1ps

module matrix_multiply_accumulate #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wen,
    input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mma_pkg::VAL_W-1:0]           cfg_data,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mma_pkg::TDATA_W-1:0]         s_tdata,   // offset[5:0], value[21:6]
    input  logic [mma_pkg::ACT_W-1:0]           s_tuser,   // action[1:0]
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mma_pkg::TDATA_W-1:0]         m_tdata,   // cell_res[5:0], result[21:6]
    output logic                                m_tlast    // last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAD_W  = mma_pkg::TDATA_W - mma_pkg::CELL_W - mma_pkg::VAL_W;

    // Configuration registers
    logic [mma_pkg::DIM_REG_W-1:0]       m_rows_reg, n_cols_reg, k_depth_reg;
    logic                                trans_a_reg, trans_b_reg;
    logic signed [mma_pkg::VAL_W-1:0]    alpha_reg, beta_reg;

    // Stores and their registered read data
    logic signed [mma_pkg::VAL_W-1:0]    a_mem [DEPTH];
    logic signed [mma_pkg::VAL_W-1:0]    b_mem [DEPTH];
    logic signed [mma_pkg::VAL_W-1:0]    c_mem [DEPTH];
    logic signed [mma_pkg::VAL_W-1:0]    a_rd_reg, b_rd_reg, c_rd_reg;

    // Input item fields
    mma_pkg::action_t                    action;
    logic [mma_pkg::CELL_W-1:0]          offset;
    logic signed [mma_pkg::VAL_W-1:0]    value;
    logic                                in_fire, start, load_ok;
    logic                                a_we, b_we, c_we;
    logic [ADDR_W-1:0]                   ld_addr, c_waddr;
    logic signed [mma_pkg::VAL_W-1:0]    c_wdata;

    // Sequencer and datapath links
    logic                                idle, emit, emit_last, out_free;
    logic [ADDR_W-1:0]                   a_addr, b_addr, c_addr;
    mma_pkg::mac_ctrl_t                  ctrl;
    logic signed [mma_pkg::VAL_W-1:0]    result;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    logic                                out_last_reg;
    logic [mma_pkg::CELL_W-1:0]          out_cell_reg;
    logic signed [mma_pkg::VAL_W-1:0]    out_res_reg;

    // Unpack the input item
    assign action  = mma_pkg::action_t'(s_tuser);
    assign offset  = s_tdata[mma_pkg::CELL_W-1:0];
    assign value   = s_tdata[mma_pkg::CELL_W +: mma_pkg::VAL_W];
    assign s_tready = idle;
    assign in_fire = s_tvalid && s_tready;
    assign start   = in_fire && (action == mma_pkg::ACT_START);
    assign load_ok = in_fire && ({1'b0, offset} < (mma_pkg::CELL_W + 1)'(DEPTH));
    assign ld_addr = offset[ADDR_W-1:0];

    assign a_we = load_ok && (action == mma_pkg::ACT_LOAD_A);
    assign b_we = load_ok && (action == mma_pkg::ACT_LOAD_B);
    assign c_we = (load_ok && (action == mma_pkg::ACT_LOAD_C)) || emit;

    // C takes loads while idle and results while computing
    assign c_waddr = emit ? c_addr : ld_addr;
    assign c_wdata = emit ? result : value;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_rows_reg  <= mma_pkg::DIM_RST;
            n_cols_reg  <= mma_pkg::DIM_RST;
            k_depth_reg <= mma_pkg::DIM_RST;
            trans_a_reg <= 1'b0;
            trans_b_reg <= 1'b0;
            alpha_reg   <= mma_pkg::ALPHA_RST;
            beta_reg    <= mma_pkg::BETA_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                mma_pkg::REG_M_ROWS:  m_rows_reg  <= cfg_data[mma_pkg::DIM_REG_W-1:0];
                mma_pkg::REG_N_COLS:  n_cols_reg  <= cfg_data[mma_pkg::DIM_REG_W-1:0];
                mma_pkg::REG_K_DEPTH: k_depth_reg <= cfg_data[mma_pkg::DIM_REG_W-1:0];
                mma_pkg::REG_TRANS_A: trans_a_reg <= cfg_data[0];
                mma_pkg::REG_TRANS_B: trans_b_reg <= cfg_data[0];
                mma_pkg::REG_ALPHA:   alpha_reg   <= cfg_data;
                mma_pkg::REG_BETA:    beta_reg    <= cfg_data;
                default:              m_rows_reg  <= m_rows_reg;
            endcase
        end
    end

    // A store: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[ld_addr] <= value;
        end
        a_rd_reg <= a_mem[a_addr];
    end

    // B store: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[ld_addr] <= value;
        end
        b_rd_reg <= b_mem[b_addr];
    end

    // C store: write on load or result, registered read
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_rd_reg <= c_mem[c_addr];
    end

    mma_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .m_rows    (m_rows_reg),
        .n_cols    (n_cols_reg),
        .k_depth   (k_depth_reg),
        .trans_a   (trans_a_reg),
        .trans_b   (trans_b_reg),
        .out_free  (out_free),
        .idle      (idle),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .c_addr    (c_addr),
        .ctrl      (ctrl),
        .emit      (emit),
        .emit_last (emit_last)
    );

    mma_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .a_rd   (a_rd_reg),
        .b_rd   (b_rd_reg),
        .c_rd   (c_rd_reg),
        .alpha  (alpha_reg),
        .beta   (beta_reg),
        .result (result)
    );

    // Output register frees when empty or being taken
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cell_reg <= mma_pkg::CELL_W'(c_addr);
            out_res_reg  <= result;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_res_reg, out_cell_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/mma_checker.sv
// ============================================================================
// mma_checker
// Port-level checks of the matrix multiply-accumulate block, bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`include "matrix_multiply_accumulate_defines.svh"

module mma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mma_pkg::ACT_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mma_pkg::TDATA_W-1:0]   m_tdata,
    input logic                          m_tlast
);

    logic start_fire;

    assign start_fire = s_tvalid && s_tready && (s_tuser == mma_pkg::ACT_START);

    // Stalled result item holds
    `MMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Input stays closed while a run has cells still to come
    `MMA_ASSERT_IMP(a_busy_mid_run, m_tvalid && !m_tlast,
        !s_tready, "input open while run unfinished")

    // A new result appears only from a busy block
    `MMA_ASSERT_IMP(a_result_from_busy, $rose(m_tvalid),
        !$past(s_tready), "result appeared while idle")

    // No result the cycle after a start with an empty output
    `MMA_ASSERT_NEXT(a_no_instant_result, start_fire && !m_tvalid,
        !m_tvalid, "result too early after start")

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
